FILE: hw/rtl/sorted_array_merge_top_defines.svh
// Assertion macros shared by the sorted array merge RTL.
`ifndef SORTED_ARRAY_MERGE_TOP_DEFINES_SVH
`define SORTED_ARRAY_MERGE_TOP_DEFINES_SVH

// Same-cycle implication, checked on every clock edge outside reset.
`define SAM_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sorted array merge check failed");

// Next-cycle implication, checked on every clock edge outside reset.
`define SAM_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sorted array merge check failed");

`endif

FILE: hw/rtl/sam_pkg.sv
// Shared constants and types for the sorted array merge block.
`default_nettype none
package sam_pkg;

  localparam int LIST_DEPTH = 32;
  localparam int ADDR_W     = $clog2(LIST_DEPTH);
  localparam int CNT_W      = $clog2(LIST_DEPTH + 1);
  localparam int TOT_W      = $clog2(2 * LIST_DEPTH + 1);
  localparam int DATA_W     = 32;
  localparam int POS_W      = 6;

  typedef enum logic [1:0] {
    OP_APPEND_FIRST  = 2'd0,
    OP_APPEND_SECOND = 2'd1,
    OP_MERGE         = 2'd2
  } sam_op_t;

  // Control from the sequencer to one list.
  typedef struct packed {
    logic append;
    logic clear;
  } sam_list_ctrl_t;

endpackage
`default_nettype wire

FILE: hw/rtl/sorted_array_merge_top.sv
// Top level of the sorted array merge block: store sequencer and merge engine.
// Store item: accepted with no result; the next item may follow at once.
// Merge item: enters the merge state, then the output register takes one result per
// cycle while out_stall is low (a single empty result if both lists are empty);
// in_stall holds until the last result; the two list memories read heads ahead at the next address.
// Synchronous active-low reset clears counts, drop flag and control; memories are not cleared.
`default_nettype none
`include "sorted_array_merge_top_defines.svh"
module sorted_array_merge_top (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               in_valid,
  output logic                                    in_stall,
  input  wire logic [1:0]                         in_operation,
  input  wire logic signed [sam_pkg::DATA_W-1:0]  in_item_value,
  output logic                                    out_valid,
  input  wire logic                               out_stall,
  output logic signed [sam_pkg::DATA_W-1:0]       out_merged_value,
  output logic      [sam_pkg::POS_W-1:0]          out_position,
  output logic                                    out_last_of_run,
  output logic                                    out_empty_merge,
  output logic                                    out_dropped_any
);
  import sam_pkg::*;

  typedef enum logic {
    ST_IDLE,
    ST_MERGE
  } state_t;

  state_t state_r;

  // Merge read pointers and output index.
  logic [CNT_W-1:0] i_r, i_nxt;
  logic [CNT_W-1:0] j_r, j_nxt;
  logic [TOT_W-1:0] k_r;
  logic             overflow_r;

  // Output register.
  logic                     out_valid_r;
  logic signed [DATA_W-1:0] out_value_r;
  logic [POS_W-1:0]         out_pos_r;
  logic                     out_last_r;
  logic                     out_empty_r;
  logic                     out_drop_r;

  sam_list_ctrl_t   first_ctrl, second_ctrl;
  logic [DATA_W-1:0] first_head, second_head;
  logic [CNT_W-1:0]  first_count, second_count;
  logic              first_full, second_full;

  logic              accept;
  logic              store_first, store_second, store_merge;
  logic              emit;
  logic [TOT_W-1:0]  total;
  logic              is_empty;
  logic              take_first;
  logic              is_last;
  logic              finish;

  assign accept       = in_valid && !in_stall;
  assign store_first  = accept && (in_operation == OP_APPEND_FIRST);
  assign store_second = accept && (in_operation == OP_APPEND_SECOND);
  assign store_merge  = accept && (in_operation == OP_MERGE);

  // Hold inputs off for the whole merge.
  assign in_stall = (state_r != ST_IDLE);

  assign total    = TOT_W'(first_count) + TOT_W'(second_count);
  assign is_empty = (total == '0);

  // Smaller head wins; the first list wins on a tie.
  always_comb begin
    if (i_r >= first_count) begin
      take_first = 1'b0;
    end else if (j_r >= second_count) begin
      take_first = 1'b1;
    end else begin
      take_first = ($signed(first_head) <= $signed(second_head));
    end
  end

  // Emit whenever the output register is free or being drained.
  assign emit    = (state_r == ST_MERGE) && (!out_valid_r || !out_stall);
  assign is_last = is_empty || ((k_r + TOT_W'(1)) == total);
  assign finish  = emit && is_last;

  // Advance the pointer of the list just taken; its memory reads ahead at the new
  // address, so the head data is ready in the next cycle.
  always_comb begin
    i_nxt = i_r;
    j_nxt = j_r;
    if (emit && !is_empty) begin
      if (take_first) begin
        i_nxt = i_r + CNT_W'(1);
      end else begin
        j_nxt = j_r + CNT_W'(1);
      end
    end
  end

  assign first_ctrl  = '{append: store_first,  clear: finish};
  assign second_ctrl = '{append: store_second, clear: finish};

  sam_list u_first (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctrl     (first_ctrl),
    .wr_value (in_item_value),
    .rd_addr  (i_nxt[ADDR_W-1:0]),
    .rd_data  (first_head),
    .count    (first_count),
    .full     (first_full)
  );

  sam_list u_second (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctrl     (second_ctrl),
    .wr_value (in_item_value),
    .rd_addr  (j_nxt[ADDR_W-1:0]),
    .rd_data  (second_head),
    .count    (second_count),
    .full     (second_full)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      i_r         <= '0;
      j_r         <= '0;
      k_r         <= '0;
      overflow_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      // Output valid: set on emit, drop once taken.
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end

      // Payload of the output register: no reset needed.
      if (emit) begin
        out_value_r <= is_empty ? '0 : (take_first ? first_head : second_head);
        out_pos_r   <= k_r[POS_W-1:0];
        out_last_r  <= is_last;
        out_empty_r <= is_empty;
        out_drop_r  <= overflow_r;
      end

      case (state_r)
        ST_IDLE: begin
          // A store into a full list is dropped and flagged.
          if ((store_first && first_full) || (store_second && second_full)) begin
            overflow_r <= 1'b1;
          end
          if (store_merge) begin
            state_r <= ST_MERGE;
          end
        end
        ST_MERGE: begin
          if (finish) begin
            state_r    <= ST_IDLE;
            i_r        <= '0;
            j_r        <= '0;
            k_r        <= '0;
            overflow_r <= 1'b0;
          end else if (emit) begin
            i_r <= i_nxt;
            j_r <= j_nxt;
            k_r <= k_r + TOT_W'(1);
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid        = out_valid_r;
  assign out_merged_value = out_value_r;
  assign out_position     = out_pos_r;
  assign out_last_of_run  = out_last_r;
  assign out_empty_merge  = out_empty_r;
  assign out_dropped_any  = out_drop_r;

  `SAM_ASSERT_NOW(a_ptr_bound, state_r == ST_MERGE,
                  (i_r <= first_count) && (j_r <= second_count))
  `SAM_ASSERT_NOW(a_index_sum, state_r == ST_MERGE,
                  k_r == (TOT_W'(i_r) + TOT_W'(j_r)))
  `SAM_ASSERT_NEXT(a_finish_clears, finish,
                   (state_r == ST_IDLE) && (first_count == '0) &&
                   (second_count == '0) && !overflow_r && out_valid_r && out_last_r)
  `SAM_ASSERT_NOW(a_idle_ptrs, state_r == ST_IDLE,
                  (i_r == '0) && (j_r == '0) && (k_r == '0))

endmodule
`default_nettype wire

FILE: hw/rtl/sam_list.sv
// One stored list: a synchronous memory with its fill count.
`default_nettype none
module sam_list (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire sam_pkg::sam_list_ctrl_t     ctrl,
  input  wire logic [sam_pkg::DATA_W-1:0]  wr_value,
  input  wire logic [sam_pkg::ADDR_W-1:0]  rd_addr,
  output logic      [sam_pkg::DATA_W-1:0]  rd_data,
  output logic      [sam_pkg::CNT_W-1:0]   count,
  output logic                             full
);
  import sam_pkg::*;

  logic [DATA_W-1:0] mem [LIST_DEPTH];
  logic [DATA_W-1:0] rd_data_r;
  logic [CNT_W-1:0]  count_r;

  assign full    = (count_r >= CNT_W'(LIST_DEPTH));
  assign count   = count_r;
  assign rd_data = rd_data_r;

  // Write at the fill position; drop the item when full.
  always_ff @(posedge clk) begin
    if (ctrl.append && !full) begin
      mem[count_r[ADDR_W-1:0]] <= wr_value;
    end
    rd_data_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (ctrl.clear) begin
      count_r <= '0;
    end else if (ctrl.append && !full) begin
      count_r <= count_r + CNT_W'(1);
    end
  end

endmodule
`default_nettype wire
